>>> hw/rtl/btd_pkg.sv
// shared types, constants and the tangent table for the bearing pipeline
package btd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int TAN_FRAC_BITS = 26;
    localparam int TAN_INT_BITS  = 6;
    localparam int TAN_BITS      = TAN_INT_BITS + TAN_FRAC_BITS;
    localparam int TAN_ENTRIES   = 90;
    localparam int MAX_DEG       = TAN_ENTRIES - 1;
    localparam int T_BITS        = $clog2(TAN_ENTRIES);
    localparam int PROD_BITS     = TAN_BITS + COORD_BITS;
    localparam int BEARING_BITS  = 9;

    localparam logic [BEARING_BITS-1:0] DEG_NORTH = BEARING_BITS'(0);
    localparam logic [BEARING_BITS-1:0] DEG_WEST  = BEARING_BITS'(90);
    localparam logic [BEARING_BITS-1:0] DEG_SOUTH = BEARING_BITS'(180);
    localparam logic [BEARING_BITS-1:0] DEG_EAST  = BEARING_BITS'(270);

    typedef logic [TAN_BITS-1:0] tan_tab_t [TAN_ENTRIES];

    typedef struct packed {
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic                  dx_neg;
        logic                  dy_neg;
        logic                  dx_zero;
        logic                  dy_zero;
        logic [T_BITS-1:0]     t;
    } btd_item_t;

    // (a*b) >> 60, q60 operands
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] qdiv_round(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] q;
        ip  = udiv64(num, den);
        rem = num - ip * den;
        q   = '0;
        for (int i = 0; i <= TAN_FRAC_BITS; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return ((ip << (TAN_FRAC_BITS + 1)) + q + 64'd1) >> 1;
    endfunction

    // tangent of whole degrees, series in q60 then rounded division
    function automatic tan_tab_t build_tan_tab();
        tan_tab_t    tab;
        logic [63:0] d;
        logic [63:0] dd;
        logic [63:0] pf;
        logic [63:0] pi_q;
        logic [63:0] per_deg;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] c;
        d  = 64'd141592653589793238;
        dd = 64'd1000000000000000000;
        pf = '0;
        for (int i = 0; i < 60; i++)
        begin
            d  = d << 1;
            pf = pf << 1;
            if (d >= dd)
            begin
                d     = d - dd;
                pf[0] = 1'b1;
            end
        end
        pi_q    = (64'd3 << 60) | pf;
        per_deg = pi_q / 64'd180;
        tab[0]  = '0;
        for (int k = 1; k <= 45; k++)
        begin
            x    = per_deg * 64'(k);
            x2   = qmul(x, x);
            term = x;
            s    = term;
            for (int n = 1; n < 30; n++)
            begin
                term = udiv64(qmul(term, x2), 64'((2 * n) * (2 * n + 1)));
                s    = n[0] ? s - term : s + term;
            end
            term = 64'd1 << 60;
            c    = term;
            for (int n = 1; n < 30; n++)
            begin
                term = udiv64(qmul(term, x2), 64'((2 * n - 1) * (2 * n)));
                c    = n[0] ? c - term : c + term;
            end
            tab[k] = TAN_BITS'(qdiv_round(s, c));
            if (k < 45)
            begin
                tab[TAN_ENTRIES - k] = TAN_BITS'(qdiv_round(c, s));
            end
        end
        return tab;
    endfunction

    localparam tan_tab_t TAN_TAB = build_tan_tab();

endpackage

>>> hw/rtl/bearing_to_target_degrees.sv
// top level: bearing in whole degrees from the vehicle to a target point
//
// input channel: in_valid/in_ready carry one beat of target_x, target_y,
// pos_x and pos_y. output channel: out_valid/out_ready carry one beat of
// bearing, 0 north, growing anticlockwise (90 west, 180 south, 270 east).
// every input beat gives exactly one output beat, in order.
// from accept to out_valid a beat passes the prep register, which forms the
// differences and magnitudes, seven search cells, each settling one bit of
// the base angle against the tangent table (one multiply and compare per
// cell), and the output register, which maps the quadrant into the bearing.
// throughput is one beat per cycle while the receiver keeps out_ready high.
// each stage holds its beat while the next one is full, so a stalled
// receiver fills the chain from the back; input is still taken while any
// stage has room. reset empties every stage; no results are pending after.
module bearing_to_target_degrees
    import btd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_BITS-1:0]   target_x,
    input  logic [COORD_BITS-1:0]   target_y,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [BEARING_BITS-1:0] bearing
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0] dx_abs;
    logic [COORD_BITS-1:0] dy_abs;
    btd_item_t             prep_next;
    btd_item_t             prep_item_reg;
    logic                  prep_valid_reg;

    logic      stage_valid [T_BITS+1];
    logic      stage_ready [T_BITS+1];
    btd_item_t stage_item  [T_BITS+1];

    assign dx     = {1'b0, target_x} - {1'b0, pos_x};
    assign dy     = {1'b0, target_y} - {1'b0, pos_y};
    assign dx_abs = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign dy_abs = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    always_comb
    begin
        prep_next.ax      = dx_abs;
        prep_next.ay      = dy_abs;
        prep_next.dx_neg  = dx[COORD_BITS];
        prep_next.dy_neg  = dy[COORD_BITS];
        prep_next.dx_zero = dx == '0;
        prep_next.dy_zero = dy == '0;
        prep_next.t       = '0;
    end

    assign in_ready = !prep_valid_reg || stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prep_item_reg <= prep_next;
        end
    end

    assign stage_valid[0] = prep_valid_reg;
    assign stage_item[0]  = prep_item_reg;

    for (genvar i = 0; i < T_BITS; i++)
    begin : g_cell
        btd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe     (T_BITS'(1) << (T_BITS - 1 - i)),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_item   (stage_item[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    btd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[T_BITS]),
        .in_ready  (stage_ready[T_BITS]),
        .in_item   (stage_item[T_BITS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bearing   (bearing)
    );

endmodule

>>> hw/rtl/btd_cell.sv
// one search cell: settles one bit of the base angle and hands the beat on
module btd_cell
    import btd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [T_BITS-1:0] probe,
    input  logic              in_valid,
    output logic              in_ready,
    input  btd_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output btd_item_t         out_item
);

    logic                 valid_reg;
    btd_item_t            item_reg;
    btd_item_t            item_next;
    logic [T_BITS-1:0]    cand;
    logic                 in_range;
    logic [T_BITS-1:0]    idx;
    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] lim;

    assign cand     = in_item.t | probe;
    assign in_range = cand <= T_BITS'(MAX_DEG);
    assign idx      = in_range ? cand : '0;
    assign prod     = PROD_BITS'(TAN_TAB[idx]) * PROD_BITS'(in_item.ax);
    assign lim      = PROD_BITS'(in_item.ay) << TAN_FRAC_BITS;

    always_comb
    begin
        item_next = in_item;
        if (in_range && (prod <= lim))
        begin
            item_next.t = cand;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hw/rtl/btd_out.sv
// output stage: maps base angle and quadrant to the bearing
module btd_out
    import btd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  btd_item_t               in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [BEARING_BITS-1:0] bearing
);

    logic                    valid_reg;
    logic [BEARING_BITS-1:0] bearing_reg;
    logic [BEARING_BITS-1:0] bearing_next;
    logic [BEARING_BITS-1:0] t_ext;

    assign t_ext = BEARING_BITS'(in_item.t);

    always_comb
    begin
        priority if (in_item.dx_zero)
        begin
            bearing_next = in_item.dy_neg ? DEG_SOUTH : DEG_NORTH;
        end
        else if (in_item.dy_zero)
        begin
            bearing_next = in_item.dx_neg ? DEG_WEST : DEG_EAST;
        end
        else if (!in_item.dy_neg)
        begin
            bearing_next = in_item.dx_neg ? DEG_WEST - t_ext : DEG_EAST + t_ext;
        end
        else
        begin
            bearing_next = in_item.dx_neg ? DEG_WEST + t_ext : DEG_EAST - t_ext;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign bearing   = bearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bearing_reg <= bearing_next;
        end
    end

endmodule
